// File: design/desa_pkg.sv
// Shared types, codes and constants of the double-ended stack allocator.
`default_nettype none

package desa_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;
    localparam int LEN_W            = 17;
    localparam int OFF_W            = 16;
    localparam int DEPTH_W          = 8;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH = 8'd2;

    typedef enum logic [2:0] {
        OP_ALLOC       = 3'd0,
        OP_FREE        = 3'd1,
        OP_GROW_KEEP   = 3'd2,
        OP_GROW_MOVE   = 3'd3,
        OP_SHRINK      = 3'd4,
        OP_ENTER_INNER = 3'd5,
        OP_ENTER_OUTER = 3'd6,
        OP_CLEAR_INNER = 3'd7
    } t_opcode;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BOTH_USED  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE   = 3'd2;
    localparam logic [2:0] ST_NO_MATCH   = 3'd3;
    localparam logic [2:0] ST_DEPTH_LOW  = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [LEN_W-1:0]   size;
        logic [OFF_W-1:0]   address;
        logic               no_address;
        logic [DEPTH_W-1:0] depth;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [OFF_W-1:0] offset;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: design/desa_in_if.sv
// Request channel: valid, ready and one request word.
`default_nettype none

interface desa_in_if;
    logic                valid;
    logic                ready;
    desa_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/desa_out_if.sv
// Response channel: valid, ready and one response word.
`default_nettype none

interface desa_out_if;
    logic                valid;
    logic                ready;
    desa_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/double_ended_stack_allocator.sv
// Top level of the double-ended stack allocator: sequencer plus datapath.
//
//   channel | dir | handshake         | word
//   --------+-----+-------------------+-------------------------------------------
//   i_in    | in  | valid/ready       | opcode, size, address, no_address, depth
//   o_out   | out | valid/ready       | status, offset
//
// Each request is first captured into the request register, then decoded
// against the region and block registers, which are updated in a single step.
// That execute step is the only path through the state, so at most one request
// is in flight; the next is captured while a response waits in the output
// register, and the execute step holds while that register is full and not taken.
// Synchronous active-low reset puts the outer region over the whole buffer,
// empties the inner region, clears out_valid and sets in_ready; no clearing pass.
`default_nettype none

module double_ended_stack_allocator #(
    parameter int BUFFER_BYTES = desa_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    desa_in_if.sink     i_in,
    desa_out_if.source  o_out
);

    desa_pkg::t_dp_cmd cmd;
    logic              in_ready;
    logic              out_valid;

    // sequencer: capture, execute, hold response until taken
    desa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // datapath: allocator state and the response word
    desa_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in.data),
        .o_out_word (o_out.data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

// File: design/desa_ctrl.sv
// Sequencer: request capture, execute step and response register handshake.
`default_nettype none

module desa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output desa_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    // execute only when the response register is free or draining now
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load   = accept;
    assign o_cmd.commit = commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: design/desa_dp.sv
// Datapath: region and block state, request decode and response register.
`default_nettype none

module desa_dp #(
    parameter int BUFFER_BYTES = desa_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  desa_pkg::t_dp_cmd   i_cmd,
    input  desa_pkg::t_in_word  i_in_word,
    output desa_pkg::t_out_word o_out_word
);

    localparam int LW = desa_pkg::LEN_W;
    localparam logic [LW-1:0] BufInit = LW'(BUFFER_BYTES);

    desa_pkg::t_in_word  r_in;
    desa_pkg::t_out_word r_out;

    logic          r_use_inner, n_use_inner;
    logic [LW-1:0] r_base [2], n_base [2];
    logic [LW-1:0] r_total[2], n_total[2];
    logic [LW-1:0] r_left [2], n_left [2];
    logic          r_tpref[2], n_tpref[2];
    logic          r_used  [4], n_used  [4];
    logic          r_placed[4], n_placed[4];
    logic [LW-1:0] r_len   [4], n_len   [4];
    logic [LW-1:0] r_start [4], n_start [4];

    desa_pkg::t_opcode op;
    logic [LW-1:0]     size;
    logic [LW-1:0]     addr;
    logic [1:0]        hi, ti;

    // current region view
    logic [LW-1:0] base, total, left, hl, tl, hs, ts;
    logic          tpref, hu, tu, hp, tp;
    logic          hit_h, hit_t, hit_o0, hit_o1;
    logic signed [LW+1:0] room_sum;
    logic          room, left_ok, both_used, alloc_tail;
    logic [2:0]    alloc_status;
    logic [LW-1:0] alloc_start, left_sub, tl_grow, hl_new;
    logic [2:0]    status;
    logic [LW-1:0] off;
    logic          apply_alloc;

    assign op   = desa_pkg::t_opcode'(r_in.opcode);
    assign size = r_in.size;
    assign addr = {1'b0, r_in.address};
    assign hi   = {r_use_inner, 1'b0};
    assign ti   = {r_use_inner, 1'b1};

    assign base  = r_use_inner ? r_base[1]  : r_base[0];
    assign total = r_use_inner ? r_total[1] : r_total[0];
    assign left  = r_use_inner ? r_left[1]  : r_left[0];
    assign tpref = r_use_inner ? r_tpref[1] : r_tpref[0];
    assign hu    = r_use_inner ? r_used[2]   : r_used[0];
    assign tu    = r_use_inner ? r_used[3]   : r_used[1];
    assign hp    = r_use_inner ? r_placed[2] : r_placed[0];
    assign tp    = r_use_inner ? r_placed[3] : r_placed[1];
    assign hl    = r_use_inner ? r_len[2]    : r_len[0];
    assign tl    = r_use_inner ? r_len[3]    : r_len[1];
    assign hs    = r_use_inner ? r_start[2]  : r_start[0];
    assign ts    = r_use_inner ? r_start[3]  : r_start[1];

    assign hit_h  = hp && !r_in.no_address && (hs == addr);
    assign hit_t  = tp && !r_in.no_address && (ts == addr);
    assign hit_o0 = r_placed[0] && !r_in.no_address && (r_start[0] == addr);
    assign hit_o1 = r_placed[1] && !r_in.no_address && (r_start[1] == addr);

    // outer region must keep room for what the inner region still holds
    assign room_sum = $signed({2'b00, r_left[0]}) - $signed({2'b00, r_total[1]})
                    + $signed({2'b00, r_left[1]});
    assign room     = r_use_inner || (room_sum >= $signed({2'b00, size}));
    assign left_ok  = (left >= size);

    assign both_used    = hu && tu;
    assign alloc_tail   = tpref ? !tu : hu;
    assign alloc_start  = alloc_tail ? (base + total - size) : base;
    assign alloc_status = !room     ? desa_pkg::ST_NO_SPACE  :
                          both_used ? desa_pkg::ST_BOTH_USED :
                          !left_ok  ? desa_pkg::ST_NO_SPACE  : desa_pkg::ST_OK;

    assign left_sub = left - size;
    assign tl_grow  = tl + size;
    assign hl_new   = hl - size;

    always_comb begin
        n_use_inner = r_use_inner;
        n_base      = r_base;
        n_total     = r_total;
        n_left      = r_left;
        n_tpref     = r_tpref;
        n_used      = r_used;
        n_placed    = r_placed;
        n_len       = r_len;
        n_start     = r_start;
        status      = desa_pkg::ST_OK;
        off         = '0;
        apply_alloc = 1'b0;

        unique case (op)
            desa_pkg::OP_ALLOC: begin
                status      = alloc_status;
                apply_alloc = (alloc_status == desa_pkg::ST_OK);
            end
            desa_pkg::OP_FREE: begin
                priority if (hit_h && hu) begin
                    n_left[r_use_inner] = left + hl;
                    n_used[hi]          = 1'b0;
                end else if (hit_t && tu) begin
                    n_left[r_use_inner] = left + tl;
                    n_used[ti]          = 1'b0;
                end else begin
                    status = desa_pkg::ST_NO_MATCH;
                end
            end
            desa_pkg::OP_GROW_KEEP, desa_pkg::OP_GROW_MOVE: begin
                priority if (!left_ok || !room) begin
                    status = desa_pkg::ST_NO_SPACE;
                end else if (hit_h) begin
                    n_left[r_use_inner] = left_sub;
                    off                 = base + hl;
                    n_len[hi]           = hl + size;
                end else if (hit_t) begin
                    n_left[r_use_inner] = left_sub;
                    n_len[ti]           = tl_grow;
                    off                 = base + total - tl_grow;
                    if (op == desa_pkg::OP_GROW_MOVE) n_start[ti] = base + total - tl_grow;
                end else if (op == desa_pkg::OP_GROW_MOVE && r_in.no_address) begin
                    status      = alloc_status;
                    apply_alloc = (alloc_status == desa_pkg::ST_OK);
                end else begin
                    status = desa_pkg::ST_NO_MATCH;
                end
            end
            desa_pkg::OP_SHRINK: begin
                priority if (hit_h && hl >= size) begin
                    n_left[r_use_inner] = left + size;
                    n_len[hi]           = hl_new;
                    if (hl_new == '0) n_used[hi] = 1'b0;
                end else if (hit_t && tl >= size) begin
                    n_left[r_use_inner] = left + size;
                    n_len[ti]           = tl - size;
                end else begin
                    status = desa_pkg::ST_NO_MATCH;
                end
            end
            desa_pkg::OP_ENTER_INNER: begin
                if (r_in.depth < desa_pkg::MIN_DEPTH) begin
                    status = desa_pkg::ST_DEPTH_LOW;
                end else begin
                    for (int b = 2; b < 4; b++) begin
                        n_used[b]   = 1'b0;
                        n_placed[b] = 1'b0;
                        n_len[b]    = '0;
                        n_start[b]  = '0;
                    end
                    n_total[1]  = r_left[0];
                    n_left[1]   = r_left[0];
                    n_base[1]   = r_used[0] ? (r_base[0] + r_len[0]) : r_base[0];
                    // odd depth: tail when input is the outer head, even: the outer tail
                    n_tpref[1]  = r_in.depth[0] ? hit_o0 : hit_o1;
                    n_use_inner = 1'b1;
                end
            end
            desa_pkg::OP_ENTER_OUTER: begin
                if (r_in.depth < desa_pkg::MIN_DEPTH) begin
                    status = desa_pkg::ST_DEPTH_LOW;
                end else begin
                    n_use_inner = 1'b0;
                end
            end
            desa_pkg::OP_CLEAR_INNER: begin
                n_base[1]  = '0;
                n_total[1] = '0;
                n_left[1]  = '0;
                n_tpref[1] = 1'b0;
                for (int b = 2; b < 4; b++) begin
                    n_used[b]   = 1'b0;
                    n_placed[b] = 1'b0;
                    n_len[b]    = '0;
                    n_start[b]  = '0;
                end
            end
        endcase

        if (apply_alloc) begin
            n_left[r_use_inner] = left_sub;
            if (alloc_tail) begin
                n_used[ti]   = 1'b1;
                n_placed[ti] = 1'b1;
                n_len[ti]    = size;
                n_start[ti]  = alloc_start;
            end else begin
                n_used[hi]   = 1'b1;
                n_placed[hi] = 1'b1;
                n_len[hi]    = size;
                n_start[hi]  = alloc_start;
            end
            off = alloc_start;
        end
    end

    // payload registers: request capture and response word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_word;
        if (i_cmd.commit) begin
            r_out.status <= status;
            r_out.offset <= off[desa_pkg::OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_inner <= 1'b0;
            r_base[0]   <= '0;
            r_base[1]   <= '0;
            r_total[0]  <= BufInit;
            r_total[1]  <= '0;
            r_left[0]   <= BufInit;
            r_left[1]   <= '0;
            r_tpref[0]  <= 1'b0;
            r_tpref[1]  <= 1'b0;
            for (int b = 0; b < 4; b++) begin
                r_used[b]   <= 1'b0;
                r_placed[b] <= 1'b0;
                r_len[b]    <= '0;
                r_start[b]  <= '0;
            end
        end else if (i_cmd.commit) begin
            r_use_inner <= n_use_inner;
            r_base      <= n_base;
            r_total     <= n_total;
            r_left      <= n_left;
            r_tpref     <= n_tpref;
            r_used      <= n_used;
            r_placed    <= n_placed;
            r_len       <= n_len;
            r_start     <= n_start;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire
